// File: design/tte_pkg.sv
package tte_pkg;

  // tap history depth
  localparam int TAP_DEPTH = 4;

  localparam int TIME_W   = 64;
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = TIME_W / DIGIT_W;
  localparam int BPM_W    = 10;
  localparam int US_W     = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W   = 2;

  // tap count holds 0..TAP_DEPTH, history index 0..TAP_DEPTH-1
  localparam int CNT_W = $clog2(TAP_DEPTH + 1);
  localparam int IDX_W = $clog2(TAP_DEPTH);

  // beats per minute numerator, microseconds per minute
  localparam int NUM_W = 26;
  localparam logic [NUM_W-1:0] BPM_NUMERATOR = 26'd60000000;

  // sequencer counter covers both the digit passes and the rate division
  localparam int SEQ_W = $clog2((DIGITS > NUM_W) ? DIGITS : NUM_W);

  // item modes
  localparam logic [MODE_W-1:0] MODE_TAP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STATUS = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TMO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_DUR  = 2'd3;

  // reset values
  localparam logic [BPM_W-1:0] RST_MIN_BPM   = 10'd40;
  localparam logic [BPM_W-1:0] RST_MAX_BPM   = 10'd300;
  localparam logic [US_W-1:0]  RST_TAP_TMO   = 24'd2000000;
  localparam logic [US_W-1:0]  RST_FLASH_DUR = 24'd100000;
  localparam logic [BPM_W-1:0] RST_TEMPO     = 10'd120;

  // control of an iterative divider
  typedef struct packed {
    logic first;
    logic step;
  } step_ctl_t;

endpackage

// File: design/tap_tempo_bpm_estimator.sv
// tap tempo estimator
// input channel (in_valid / in_stall) carries mode, now_us and new_bpm; an
// item is taken when in_valid is high and in_stall is low. every item gives
// exactly one result item on the output channel (out_valid / out_stall):
// the tempo in bpm, whether a tap produced a new estimate, and the flash.
// configuration goes through cfg_we / cfg_index / cfg_data; the user is to
// write it only while idle, which the block itself does not enforce.
// timing: all 64-bit time arithmetic runs one 4-bit digit per cycle, so a
// first pass computes the tap gap, the span of the history and the flash
// age. a tap that leaves two or more taps then divides the span by one less
// than the tap count (one digit per cycle) and divides 60000000 by that
// average (one quotient bit per cycle).
// one item is in work at a time; in_stall drops as the result is loaded, so
// a new item is taken only once the result of the last one is loaded.
// a stalled result holds in the output register; the next item may be taken
// and worked on meanwhile, and its result waits until the register frees.
// synchronous reset restores the register defaults, tempo 120, an empty tap
// history and the flash off.
module tap_tempo_bpm_estimator (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tte_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tte_pkg::MODE_W-1:0]    mode,
  input  logic [tte_pkg::TIME_W-1:0]    now_us,
  input  logic [tte_pkg::BPM_W-1:0]     new_bpm,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tte_pkg::BPM_W-1:0]     bpm,
  output logic                          updated,
  output logic                          flashing
);
  import tte_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PASS = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_AVG  = 3'd3;
  localparam logic [2:0] S_RATE = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // configuration registers
  logic [BPM_W-1:0] min_bpm;
  logic [BPM_W-1:0] max_bpm;
  logic [US_W-1:0]  tap_timeout_us;
  logic [US_W-1:0]  flash_duration_us;

  // control state
  logic [2:0]       state;
  logic [SEQ_W-1:0] cnt;
  logic [CNT_W-1:0] taps_held;
  logic [BPM_W-1:0] tempo;
  logic             flash_on;

  // payload
  logic [TIME_W-1:0] tap_history [TAP_DEPTH];
  logic [TIME_W-1:0] now_sr;
  logic [TIME_W-1:0] flash_start;
  logic [US_W-1:0]   tmo_sr;
  logic [US_W-1:0]   dur_sr;
  logic [MODE_W-1:0] mode_r;
  logic [BPM_W-1:0]  new_bpm_r;
  logic              res_upd;
  logic              res_fl;

  logic in_take;
  logic out_free;
  logic pass_en;
  logic pass_first;
  logic last_pass_digit;

  // digit taps of the first pass
  logic [IDX_W-1:0]   last_idx;
  logic [DIGIT_W-1:0] now_d;
  logic [DIGIT_W-1:0] last_d;
  logic [DIGIT_W-1:0] first_d;
  logic [DIGIT_W-1:0] fs_d;
  logic [DIGIT_W-1:0] gap_d;
  logic [DIGIT_W-1:0] tot_d;
  logic [DIGIT_W-1:0] age_d;
  logic               tmo_carry;
  logic               dur_carry;

  // evaluation
  logic             tmo_hit;
  logic             young;
  logic [CNT_W-1:0] taps_eff;
  logic [CNT_W-1:0] taps_new;

  // dividers
  step_ctl_t         avg_ctl;
  step_ctl_t         rate_ctl;
  logic [TIME_W-1:0] avg_q;
  logic [NUM_W-1:0]  rate_q;
  logic              avg_big;
  logic              avg_zero;

  // min clamp first, then max
  function automatic logic [BPM_W-1:0] clamp_bpm(
    input logic [NUM_W-1:0] v,
    input logic [BPM_W-1:0] lo,
    input logic [BPM_W-1:0] hi
  );
    logic [NUM_W-1:0] w;
    w = (v < NUM_W'(lo)) ? NUM_W'(lo) : v;
    w = (w > NUM_W'(hi)) ? NUM_W'(hi) : w;
    return w[BPM_W-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pass_en         = (state == S_PASS);
  assign pass_first      = pass_en && (cnt == '0);
  assign last_pass_digit = (cnt == SEQ_W'(DIGITS - 1));

  // newest stored tap, and the oldest tap that survives this one
  assign last_idx = (taps_held == '0) ? '0 : IDX_W'(taps_held - 1'b1);
  assign now_d    = now_sr[DIGIT_W-1:0];
  assign fs_d     = flash_start[DIGIT_W-1:0];
  assign first_d  = (taps_held == CNT_W'(TAP_DEPTH)) ? tap_history[1][DIGIT_W-1:0]
                                                      : tap_history[0][DIGIT_W-1:0];

  always_comb begin
    last_d = tap_history[0][DIGIT_W-1:0];
    for (int i = 0; i < TAP_DEPTH; i++) begin
      if (last_idx == IDX_W'(i)) begin
        last_d = tap_history[i][DIGIT_W-1:0];
      end
    end
  end

  // gap since the last tap, checked against the timeout
  tte_dsub u_gap (
    .clk(clk), .first(pass_first), .en(pass_en),
    .a(now_d), .b(last_d), .d(gap_d), .carry()
  );
  tte_dsub u_tmo (
    .clk(clk), .first(pass_first), .en(pass_en),
    .a(tmo_sr[DIGIT_W-1:0]), .b(gap_d), .d(), .carry(tmo_carry)
  );

  // span of the history after this tap
  tte_dsub u_span (
    .clk(clk), .first(pass_first), .en(pass_en),
    .a(now_d), .b(first_d), .d(tot_d), .carry()
  );

  // flash age, checked against the flash duration
  tte_dsub u_age (
    .clk(clk), .first(pass_first), .en(pass_en),
    .a(now_d), .b(fs_d), .d(age_d), .carry()
  );
  tte_dsub u_dur (
    .clk(clk), .first(pass_first), .en(pass_en),
    .a(age_d), .b(dur_sr[DIGIT_W-1:0]), .d(), .carry(dur_carry)
  );

  // borrow out of timeout - gap means the gap is past the timeout
  assign tmo_hit  = (taps_held != '0) && !tmo_carry;
  // borrow out of age - duration means the flash is still young
  assign young    = !dur_carry;
  assign taps_eff = tmo_hit ? '0 : taps_held;
  assign taps_new = (taps_eff < CNT_W'(TAP_DEPTH)) ? taps_eff + 1'b1 : CNT_W'(TAP_DEPTH);

  // average interval: span over (taps - 1), then the bpm quotient
  assign avg_ctl.first  = (state == S_AVG) && (cnt == '0);
  assign avg_ctl.step   = (state == S_AVG);
  assign rate_ctl.first = (state == S_RATE) && (cnt == '0);
  assign rate_ctl.step  = (state == S_RATE);

  tte_avg_div u_avg (
    .clk(clk), .shift(pass_en), .din(tot_d), .ctl(avg_ctl),
    .divisor(taps_held - 1'b1), .quot(avg_q)
  );

  tte_rate_div u_rate (
    .clk(clk), .ctl(rate_ctl), .divisor(avg_q[NUM_W-1:0]), .quot(rate_q)
  );

  // an average of 2^26 or more gives a quotient of zero
  assign avg_big  = |avg_q[TIME_W-1:NUM_W];
  assign avg_zero = ~|avg_q;

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_bpm           <= RST_MIN_BPM;
      max_bpm           <= RST_MAX_BPM;
      tap_timeout_us    <= RST_TAP_TMO;
      flash_duration_us <= RST_FLASH_DUR;
      state             <= S_IDLE;
      cnt               <= '0;
      taps_held         <= '0;
      tempo             <= RST_TEMPO;
      flash_on          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_BPM:   min_bpm           <= cfg_data[BPM_W-1:0];
          CFG_MAX_BPM:   max_bpm           <= cfg_data[BPM_W-1:0];
          CFG_TAP_TMO:   tap_timeout_us    <= cfg_data[US_W-1:0];
          CFG_FLASH_DUR: flash_duration_us <= cfg_data[US_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            cnt   <= '0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          cnt <= cnt + 1'b1;
          if (last_pass_digit) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          cnt   <= '0;
          state <= S_DONE;
          unique case (mode_r)
            MODE_TAP: begin
              flash_on  <= 1'b1;
              taps_held <= taps_new;
              if (taps_new >= CNT_W'(2)) begin
                state <= S_AVG;
              end
            end
            MODE_SET: begin
              tempo <= clamp_bpm(NUM_W'(new_bpm_r), min_bpm, max_bpm);
            end
            MODE_UPDATE: begin
              flash_on <= flash_on && young;
            end
            default: ;
          endcase
        end
        S_AVG: begin
          cnt <= cnt + 1'b1;
          if (last_pass_digit) begin
            cnt   <= '0;
            state <= S_RATE;
          end
        end
        S_RATE: begin
          cnt <= cnt + 1'b1;
          if (cnt == SEQ_W'(NUM_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          tempo <= avg_zero ? max_bpm
                            : clamp_bpm(avg_big ? '0 : rate_q, min_bpm, max_bpm);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r    <= mode;
      new_bpm_r <= new_bpm;
      now_sr    <= now_us;
      tmo_sr    <= tap_timeout_us;
      dur_sr    <= flash_duration_us;
    end

    // rotate the time words a full turn during the pass
    if (pass_en) begin
      now_sr      <= {now_sr[DIGIT_W-1:0], now_sr[TIME_W-1:DIGIT_W]};
      flash_start <= {flash_start[DIGIT_W-1:0], flash_start[TIME_W-1:DIGIT_W]};
      tmo_sr      <= {{DIGIT_W{1'b0}}, tmo_sr[US_W-1:DIGIT_W]};
      dur_sr      <= {{DIGIT_W{1'b0}}, dur_sr[US_W-1:DIGIT_W]};
      for (int i = 0; i < TAP_DEPTH; i++) begin
        tap_history[i] <= {tap_history[i][DIGIT_W-1:0],
                           tap_history[i][TIME_W-1:DIGIT_W]};
      end
    end

    if (state == S_EVAL) begin
      res_upd <= 1'b0;
      case (mode_r)
        MODE_TAP: begin
          flash_start <= now_sr;
          res_fl      <= (flash_duration_us != '0);
          // append, or drop the oldest when the history is full
          for (int i = 0; i < TAP_DEPTH; i++) begin
            if (taps_eff == CNT_W'(TAP_DEPTH)) begin
              if (i == TAP_DEPTH - 1) begin
                tap_history[i] <= now_sr;
              end else begin
                tap_history[i] <= tap_history[i + 1];
              end
            end else if (taps_eff == CNT_W'(i)) begin
              tap_history[i] <= now_sr;
            end
          end
        end
        default: res_fl <= flash_on && young;
      endcase
    end

    if (state == S_FIN) begin
      res_upd <= 1'b1;
    end

    if (state == S_DONE && out_free) begin
      bpm      <= tempo;
      updated  <= res_upd;
      flashing <= res_fl;
    end
  end

endmodule

// File: design/tte_dsub.sv
module tte_dsub (
  input  logic                        clk,
  input  logic                        first,
  input  logic                        en,
  input  logic [tte_pkg::DIGIT_W-1:0] a,
  input  logic [tte_pkg::DIGIT_W-1:0] b,
  output logic [tte_pkg::DIGIT_W-1:0] d,
  output logic                        carry
);
  import tte_pkg::*;

  logic               cin;
  logic [DIGIT_W:0]   sum;

  // a - b one digit at a time, lsb digit first; carry high means no borrow
  assign cin = first ? 1'b1 : carry;
  assign sum = {1'b0, a} + {1'b0, ~b} + {{DIGIT_W{1'b0}}, cin};
  assign d   = sum[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      carry <= sum[DIGIT_W];
    end
  end

endmodule

// File: design/tte_avg_div.sv
module tte_avg_div (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [tte_pkg::DIGIT_W-1:0] din,
  input  tte_pkg::step_ctl_t          ctl,
  input  logic [tte_pkg::CNT_W-1:0]   divisor,
  output logic [tte_pkg::TIME_W-1:0]  quot
);
  import tte_pkg::*;

  logic [TIME_W-1:0]  total;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   rem_next;
  logic [DIGIT_W-1:0] qdig;

  // restoring division, one digit of the total per cycle, msb digit first
  always_comb begin
    logic [CNT_W:0] trial;
    rem_next = ctl.first ? '0 : rem;
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      trial = {rem_next, total[TIME_W - DIGIT_W + k]};
      if (trial >= {1'b0, divisor}) begin
        rem_next = CNT_W'(trial - {1'b0, divisor});
        qdig[k]  = 1'b1;
      end else begin
        rem_next = trial[CNT_W-1:0];
        qdig[k]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      total <= {din, total[TIME_W-1:DIGIT_W]};
    end else if (ctl.step) begin
      total <= {total[TIME_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      quot  <= {quot[TIME_W-DIGIT_W-1:0], qdig};
      rem   <= rem_next;
    end
  end

endmodule

// File: design/tte_rate_div.sv
module tte_rate_div (
  input  logic                       clk,
  input  tte_pkg::step_ctl_t         ctl,
  input  logic [tte_pkg::NUM_W-1:0]  divisor,
  output logic [tte_pkg::NUM_W-1:0]  quot
);
  import tte_pkg::*;

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] cur_rem;
  logic [NUM_W-1:0] cur_num;
  logic [NUM_W:0]   trial;
  logic             ge;

  // radix-2 restoring division of the per-minute constant, one bit a cycle
  assign cur_rem = ctl.first ? '0 : rem;
  assign cur_num = ctl.first ? BPM_NUMERATOR : num;
  assign trial   = {cur_rem, cur_num[NUM_W-1]};
  assign ge      = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      rem  <= ge ? NUM_W'(trial - {1'b0, divisor}) : trial[NUM_W-1:0];
      num  <= {cur_num[NUM_W-2:0], 1'b0};
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

endmodule

// File: design/tte_checker.sv
module tte_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [tte_pkg::BPM_W-1:0] bpm,
  input logic                      updated,
  input logic                      flashing
);
  import tte_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] owed;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // items taken whose results are not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= 2'd0;
    end else begin
      owed <= owed + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bpm) && $stable(updated)
                               && $stable(flashing))
    else $error("stalled result changed");

  // no result without an item owed
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> owed != 2'd0)
    else $error("result with no item pending");

  // at most one item in work and one result waiting
  a_owed_max: assert property (@(posedge clk) disable iff (rst)
    owed != 2'd3)
    else $error("too many items pending");

  // an accepted item stalls the input at the start of the first pass
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken while busy");

  // a result is loaded as the sequencer returns to idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded while sequencer busy");

endmodule

bind tap_tempo_bpm_estimator tte_checker u_tte_checker (.*);

// File: verif/tap_tempo_bpm_estimator_tb.sv
module tap_tempo_bpm_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tte_pkg::*;

  // one result item as the block reports it
  typedef struct packed {
    logic [BPM_W-1:0] bpm;
    logic             upd;
    logic             fl;
  } beat_t;

  // directed row: stimulus plus, where obvious, the result typed in
  typedef struct {
    logic [MODE_W-1:0] md;
    logic [TIME_W-1:0] t;
    logic [BPM_W-1:0]  req;
    bit                typed;
    logic [BPM_W-1:0]  w_bpm;
    bit                w_upd;
    bit                w_fl;
  } cue_t;

  localparam int NCUE        = 23;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 180;
  // long receiver hold-off: starts after this many results, lasts this many cycles
  localparam int HOLD_AT     = 250;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_CYCLES = 80;

  // dut ports
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode      = MODE_STATUS;
  logic [TIME_W-1:0]    now_us    = '0;
  logic [BPM_W-1:0]     new_bpm   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BPM_W-1:0]     bpm;
  logic                 updated;
  logic                 flashing;

  // predictor copy of the registers
  logic [BPM_W-1:0] lo_bpm;
  logic [BPM_W-1:0] hi_bpm;
  logic [US_W-1:0]  tmo;
  logic [US_W-1:0]  fdur;

  // predictor copy of the tap and flash state
  logic [TIME_W-1:0] hist [TAP_DEPTH];
  int                n_taps;
  logic [BPM_W-1:0]  tempo;
  bit                fl_on;
  logic [TIME_W-1:0] fl_start;

  beat_t beats_due [$];
  int    n_bad  = 0;
  int    n_seen = 0;
  bit    quiet  = 1'b0;

  // running timestamp of the random well-formed stream
  logic [TIME_W-1:0] t_now;

  cue_t cue_list [NCUE];

  tap_tempo_bpm_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .now_us    (now_us),
    .new_bpm   (new_bpm),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bpm       (bpm),
    .updated   (updated),
    .flashing  (flashing)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tempo predictor
  // ---------------------------------------------------------------------------

  // state right after reset
  function automatic void forget_all();
    lo_bpm   = RST_MIN_BPM;
    hi_bpm   = RST_MAX_BPM;
    tmo      = RST_TAP_TMO;
    fdur     = RST_FLASH_DUR;
    for (int k = 0; k < TAP_DEPTH; k++) hist[k] = '0;
    n_taps   = 0;
    tempo    = RST_TEMPO;
    fl_on    = 1'b0;
    fl_start = '0;
  endfunction

  // lower bound first, then upper bound, so an inverted range lands on max
  function automatic logic [BPM_W-1:0] clamp_bpm(logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] c;
    c = v;
    if (c < TIME_W'(lo_bpm)) c = TIME_W'(lo_bpm);
    if (c > TIME_W'(hi_bpm)) c = TIME_W'(hi_bpm);
    return c[BPM_W-1:0];
  endfunction

  // advances the predictor by one item and returns the result it should give
  function automatic beat_t tempo_step(logic [MODE_W-1:0] md, logic [TIME_W-1:0] t,
                                       logic [BPM_W-1:0] req);
    beat_t             r;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] avg;
    logic [TIME_W-1:0] est;
    r.upd = 1'b0;
    case (md)
      MODE_TAP: begin
        fl_on    = 1'b1;
        fl_start = t;
        // gap wraps modulo 2^64; too long a gap restarts the history
        if (n_taps > 0 && (t - hist[n_taps-1]) > TIME_W'(tmo)) n_taps = 0;
        if (n_taps < TAP_DEPTH) begin
          hist[n_taps] = t;
          n_taps++;
        end else begin
          // history full: slide out the oldest tap
          for (int k = 0; k < TAP_DEPTH - 1; k++) hist[k] = hist[k+1];
          hist[TAP_DEPTH-1] = t;
        end
        if (n_taps >= 2) begin
          span = hist[n_taps-1] - hist[0];
          avg  = span / TIME_W'(n_taps - 1);
          if (avg == '0) begin
            // zero interval goes to the top of the range
            est = (lo_bpm > hi_bpm) ? TIME_W'(lo_bpm) : TIME_W'(hi_bpm);
          end else begin
            est = TIME_W'(BPM_NUMERATOR) / avg;
          end
          tempo = clamp_bpm(est);
          r.upd = 1'b1;
        end
      end
      MODE_SET: tempo = clamp_bpm(TIME_W'(req));
      MODE_UPDATE: begin
        if (fl_on && (t - fl_start) >= TIME_W'(fdur)) fl_on = 1'b0;
      end
      default: ;
    endcase
    r.bpm = tempo;
    r.fl  = fl_on && ((t - fl_start) < TIME_W'(fdur));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration writes, only while nothing is in flight
  // ---------------------------------------------------------------------------

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_MIN_BPM:   lo_bpm = val[BPM_W-1:0];
      CFG_MAX_BPM:   hi_bpm = val[BPM_W-1:0];
      CFG_TAP_TMO:   tmo    = val[US_W-1:0];
      CFG_FLASH_DUR: fdur   = val[US_W-1:0];
      default: ;
    endcase
  endtask

  // bpm registers get random junk above bit 9, which the block must drop
  task automatic load_setting(logic [BPM_W-1:0] lo_v, logic [BPM_W-1:0] hi_v,
                              logic [US_W-1:0] tmo_v, logic [US_W-1:0] dur_v);
    cfg_write(CFG_MIN_BPM,   {(CFG_W-BPM_W)'($urandom), lo_v});
    cfg_write(CFG_MAX_BPM,   {(CFG_W-BPM_W)'($urandom), hi_v});
    cfg_write(CFG_TAP_TMO,   tmo_v);
    cfg_write(CFG_FLASH_DUR, dur_v);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // idle cycles between items: mostly none, some short, a few long
  task automatic sender_gap();
    int g;
    int n;
    if (quiet) return;
    g = $urandom_range(0, 9);
    n = (g < 6) ? 0 : (g < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // offers one item, holds it until taken, then books its expected result
  task automatic offer(logic [MODE_W-1:0] md, logic [TIME_W-1:0] t, logic [BPM_W-1:0] req,
                       bit typed, beat_t want);
    beat_t got;
    in_valid <= 1'b1;
    mode     <= md;
    now_us   <= t;
    new_bpm  <= req;
    do @(posedge clk); while (in_stall);
    got = tempo_step(md, t, req);
    beats_due.push_back(typed ? want : got);
  endtask

  // one random item: mostly a plausible tap / flash stream, some noise
  task automatic rand_item();
    int                r;
    int                s;
    logic [MODE_W-1:0] md;
    logic [TIME_W-1:0] t;
    logic [BPM_W-1:0]  req;
    r   = $urandom_range(0, 99);
    s   = $urandom_range(0, 19);
    req = BPM_W'($urandom_range(0, 1023));
    if (r < 45) begin
      md = MODE_TAP;
      if (s == 0) begin
        // same instant as last tap
      end else if (s == 1) begin
        t_now += TIME_W'(tmo);                           // gap right at the timeout
      end else if (s == 2) begin
        t_now += TIME_W'(tmo) + 1;                       // just past the timeout
      end else if (s == 3) begin
        t_now += TIME_W'(tmo) + TIME_W'($urandom_range(2, 1 << 24));
      end else if (s == 4) begin
        t_now -= TIME_W'($urandom_range(1, 1000));       // clock going backwards
      end else if (s < 7) begin
        t_now += TIME_W'($urandom_range(1, 300));        // very fast taps
      end else if (s < 13) begin
        t_now += TIME_W'($urandom_range(1, tmo));
      end else if (tmo > 1500000) begin
        t_now += TIME_W'($urandom_range(200000, 1500000)); // human tempo
      end else begin
        t_now += TIME_W'($urandom_range(1, tmo));
      end
      t = t_now;
    end else if (r < 70) begin
      md = MODE_UPDATE;
      // hit the flash end exactly, one short of it, or somewhere around
      if (s == 0) t_now = fl_start + TIME_W'(fdur);
      else if (s == 1) t_now = fl_start + TIME_W'(fdur) - 1;
      else t_now += TIME_W'($urandom_range(0, fdur / 2 + 1));
      t = t_now;
    end else if (r < 80) begin
      md = MODE_SET;
      t_now += TIME_W'($urandom_range(0, 1000));
      t = t_now;
    end else if (r < 85) begin
      md = MODE_STATUS;
      t  = t_now;
    end else begin
      // noise: any mode at any time
      md = MODE_W'($urandom_range(0, 3));
      t  = {$urandom, $urandom};
    end
    offer(md, t, req, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls plus one long hold-off to back the block up
  // ---------------------------------------------------------------------------

  int  stall_left = 0;
  int  hold_left  = 0;
  bit  held       = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!held && n_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker: every taken result against the oldest expectation
  always @(posedge clk) begin : watch
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      n_seen <= n_seen + 1;
      if (beats_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: bpm=%0d updated=%0b flashing=%0b",
                   bpm, updated, flashing);
      end else begin
        want = beats_due.pop_front();
        if ({bpm, updated, flashing} !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch at %0t: bpm %0d/%0d updated %0b/%0b flashing %0b/%0b (exp/got)",
                     $realtime, want.bpm, bpm, want.upd, updated, want.fl, flashing);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    forget_all();

    // directed rows at reset settings: clamps, history build-up and slide,
    // timeout edge, backwards and wrapping clock, flash end, field extremes
    cue_list = '{
      '{MODE_STATUS, 64'd0,        10'd0,   1'b1, 10'd120, 1'b0, 1'b0},
      '{MODE_UPDATE, 64'd0,        10'd0,   1'b1, 10'd120, 1'b0, 1'b0},
      '{MODE_SET,    64'd0,        10'd0,   1'b1, 10'd40,  1'b0, 1'b0},
      '{MODE_SET,    64'd0,        10'h3FF, 1'b1, 10'd300, 1'b0, 1'b0},
      '{MODE_SET,    64'd10,       10'd200, 1'b1, 10'd200, 1'b0, 1'b0},
      '{MODE_TAP,    64'd1000,     10'd0,   1'b1, 10'd200, 1'b0, 1'b1},
      '{MODE_TAP,    64'd1000,     10'd0,   1'b1, 10'd300, 1'b1, 1'b1},
      '{MODE_TAP,    64'd501000,   10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'd1001000,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'd1501000,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_UPDATE, 64'd1550000,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_UPDATE, 64'd1601000,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_STATUS, 64'd1700000,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'd9000000,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'd9000100,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'd11000100, 10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'd11000101, 10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'd5,        10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_TAP,    64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 1'b0, 10'd0, 1'b0, 1'b0},
      '{MODE_TAP,    64'd1999999,  10'd0,   1'b0, 10'd0,   1'b0, 1'b0},
      '{MODE_SET,    64'hAAAA_AAAA_AAAA_AAAA, 10'h2AA, 1'b0, 10'd0, 1'b0, 1'b0},
      '{MODE_SET,    64'h5555_5555_5555_5555, 10'h155, 1'b0, 10'd0, 1'b0, 1'b0},
      '{MODE_UPDATE, 64'h5555_5555_5555_5555, 10'd0,   1'b0, 10'd0, 1'b0, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (cue_list[i]) begin
      sender_gap();
      offer(cue_list[i].md, cue_list[i].t, cue_list[i].req, cue_list[i].typed,
            beat_t'{cue_list[i].w_bpm, cue_list[i].w_upd, cue_list[i].w_fl});
    end
    drain();

    // random phases, each under its own register setting
    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: load_setting(10'd1, 10'd1023, 24'hFFFFFF, 24'hFFFFFF); // widest range
        2: load_setting(10'd1023, 10'd1, 24'd1, 24'd0);           // inverted, no flash
        3: load_setting(10'd60, 10'd200, 24'd1000000, 24'd50000);
        default: load_setting(BPM_W'($urandom_range(1, 1023)),
                              BPM_W'($urandom_range(1, 1023)),
                              US_W'($urandom_range(1, 24'hFFFFFF)),
                              US_W'($urandom_range(0, 24'hFFFFFF)));
      endcase
      // one phase runs right at the 64-bit wrap, one without any idling
      t_now = (p == 2) ? 64'hFFFF_FFFF_FF00_0000 : {$urandom, $urandom};
      quiet = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sender_gap();
        rand_item();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0 && beats_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
